@@ design/plt_enc_pkg.sv @@
// Types, opcodes and word-building functions for the PLT trampoline encoder.
`timescale 1ns / 1ps

package plt_enc_pkg;

  localparam logic [31:0] OP_NOP       = 32'h0100_0000;
  localparam logic [31:0] OP_BA_A_PT   = 32'h3048_0000;
  localparam logic [31:0] OP_BA_A      = 32'h3080_0000;
  localparam logic [31:0] OP_SETHI_G5  = 32'h0b00_0000;
  localparam logic [31:0] OP_SETHI_G1  = 32'h0300_0000;
  localparam logic [31:0] OP_XNOR_G5G1 = 32'h8239_6000;
  localparam logic [31:0] OP_JMPL_G1   = 32'h81c0_6000;
  localparam logic [31:0] OP_SLLX12    = 32'h8328_700c;
  localparam logic [31:0] OP_SLLX32    = 32'h8328_7020;
  localparam logic [31:0] OP_OR_G1IMM  = 32'h8210_6000;
  localparam logic [31:0] OP_OR_G1G5G5 = 32'h8a10_4005;
  localparam logic [31:0] OP_JMPL_G5   = 32'h81c1_6000;

  typedef enum logic [2:0] {
    FORM_SHORT = 3'd0,
    FORM_BRANCH = 3'd1,
    FORM_TOP32 = 3'd2,
    FORM_TOP44 = 3'd3,
    FORM_ABS64 = 3'd4
  } form_e;

  // Classified entry waiting in the queue
  typedef struct packed {
    form_e       form;
    logic [21:0] disp_bits;  // displacement bits 23..2
    logic [63:0] target;
  } job_t;

  function automatic logic [2:0] last_index(form_e form);
    logic [2:0] idx;
    case (form)
      FORM_SHORT:  idx = 3'd2;
      FORM_BRANCH: idx = 3'd2;
      FORM_TOP32:  idx = 3'd3;
      FORM_TOP44:  idx = 3'd4;
      FORM_ABS64:  idx = 3'd6;
      default:     idx = 3'd6;
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] build_word(job_t job, logic [2:0] k);
    logic [63:0] inv;
    logic [31:0] w;
    inv = ~job.target;
    w   = OP_NOP;
    case (job.form)
      FORM_SHORT: begin
        if (k == 3'd1) w = OP_BA_A_PT | {13'd0, job.disp_bits[18:0]};
      end
      FORM_BRANCH: begin
        if (k == 3'd1) w = OP_BA_A | {10'd0, job.disp_bits};
      end
      FORM_TOP32: begin
        case (k)
          3'd1:    w = OP_SETHI_G5 | {10'd0, inv[31:10]};
          3'd2:    w = OP_XNOR_G5G1 | {22'd0, inv[9:0]};
          3'd3:    w = OP_JMPL_G1;
          default: w = OP_NOP;
        endcase
      end
      FORM_TOP44: begin
        case (k)
          3'd1:    w = OP_SETHI_G5 | {10'd0, inv[43:22]};
          3'd2:    w = OP_XNOR_G5G1 | {22'd0, inv[21:12]};
          3'd3:    w = OP_SLLX12;
          3'd4:    w = OP_JMPL_G1 | {20'd0, job.target[11:0]};
          default: w = OP_NOP;
        endcase
      end
      FORM_ABS64: begin
        case (k)
          3'd1:    w = OP_SETHI_G1 | {10'd0, job.target[63:42]};
          3'd2:    w = OP_SETHI_G5 | {10'd0, job.target[31:10]};
          3'd3:    w = OP_OR_G1IMM | {22'd0, job.target[41:32]};
          3'd4:    w = OP_SLLX32;
          3'd5:    w = OP_OR_G1G5G5;
          3'd6:    w = OP_JMPL_G5 | {22'd0, job.target[9:0]};
          default: w = OP_NOP;
        endcase
      end
      default: w = OP_NOP;
    endcase
    return w;
  endfunction

endpackage

@@ design/plt_enc_front.sv @@
// Front end: computes the displacement and picks the shortest reaching form.
`timescale 1ns / 1ps

module plt_enc_front (
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [63:0]          entry_addr_i,
  input  logic [63:0]          target_addr_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output plt_enc_pkg::job_t    job_o
);

  logic [63:0] disp;
  logic        fits_short;
  logic        fits_branch;
  logic        fits_top32;
  logic        fits_top44;

  assign disp        = target_addr_i - entry_addr_i - 64'd4;
  assign fits_short  = (&disp[63:20]) || !(|disp[63:20]);
  assign fits_branch = (&disp[63:23]) || !(|disp[63:23]);
  assign fits_top32  = &target_addr_i[63:32];
  assign fits_top44  = &target_addr_i[63:44];

  always_comb begin
    job_o.disp_bits = disp[23:2];
    job_o.target    = target_addr_i;
    if (fits_short) begin
      job_o.form = plt_enc_pkg::FORM_SHORT;
    end else if (fits_branch) begin
      job_o.form = plt_enc_pkg::FORM_BRANCH;
    end else if (fits_top32) begin
      job_o.form = plt_enc_pkg::FORM_TOP32;
    end else if (fits_top44) begin
      job_o.form = plt_enc_pkg::FORM_TOP44;
    end else begin
      job_o.form = plt_enc_pkg::FORM_ABS64;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

@@ design/plt_enc_queue.sv @@
// Small register queue of classified entries between front and back ends.
`timescale 1ns / 1ps

module plt_enc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  plt_enc_pkg::job_t  push_job_i,
  input  logic               pop_i,
  output logic               full_o,
  output logic               head_valid_o,
  output plt_enc_pkg::job_t  head_job_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  plt_enc_pkg::job_t entries_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;

  assign full_o       = (count_q == CntW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_job_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ design/plt_enc_back.sv @@
// Back end: walks the head entry one instruction word per beat into the output register.
`timescale 1ns / 1ps

module plt_enc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               head_valid_i,
  input  plt_enc_pkg::job_t  head_job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         word_index_o,
  output logic [31:0]        instr_word_o,
  output logic [2:0]         form_code_o,
  output logic               last_word_o
);

  logic [2:0]  k_q, k_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  idx_q;
  logic [31:0] word_q;
  logic [2:0]  form_q;
  logic        last_q;
  logic        load;
  logic        is_last;

  assign load    = head_valid_i && (!out_valid_q || !out_stall_i);
  assign is_last = (k_q == plt_enc_pkg::last_index(head_job_i.form));
  assign pop_o   = load && is_last;

  always_comb begin
    k_d         = k_q;
    out_valid_d = out_valid_q;
    if (load) begin
      k_d         = is_last ? 3'd0 : k_q + 3'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      idx_q  <= k_q;
      word_q <= plt_enc_pkg::build_word(head_job_i, k_q);
      form_q <= head_job_i.form;
      last_q <= is_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign word_index_o = idx_q;
  assign instr_word_o = word_q;
  assign form_code_o  = form_q;
  assign last_word_o  = last_q;

endmodule

@@ design/plt_trampoline_encoder.sv @@
// Top level of the SPARC V9 PLT trampoline encoder.
`timescale 1ns / 1ps

// Each accepted beat (entry address, target address) is classified in the
// same cycle and queued; the back end then emits the instruction words of
// the chosen form, one beat per cycle unless the output stalls, in ascending
// word order with the last word flagged: 3 beats for the branch forms, 4 for
// the top-32 jump, 5 for the top-44 jump and 7 for the absolute form. The
// single result port serves one entry at a time; the first word passes
// through the queue and the output register. The queue holds QUEUE_DEPTH
// entries, the one being emitted among them, so input is taken while the
// output side stalls until the queue fills.
module plt_trampoline_encoder #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] entry_addr_i,
  input  logic [63:0] target_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  word_index_o,
  output logic [31:0] instr_word_o,
  output logic [2:0]  form_code_o,
  output logic        last_word_o
);

  logic              push;
  logic              pop;
  logic              q_full;
  logic              head_valid;
  plt_enc_pkg::job_t push_job;
  plt_enc_pkg::job_t head_job;

  plt_enc_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .entry_addr_i  (entry_addr_i),
    .target_addr_i (target_addr_i),
    .q_full_i      (q_full),
    .push_o        (push),
    .job_o         (push_job)
  );

  plt_enc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  plt_enc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .word_index_o (word_index_o),
    .instr_word_o (instr_word_o),
    .form_code_o  (form_code_o),
    .last_word_o  (last_word_o)
  );

endmodule

@@ design/plt_enc_checker.sv @@
// Port-level checks on the encoder's output sequence, bound to the top level.
`timescale 1ns / 1ps

module plt_enc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  word_index_o,
  input logic [31:0] instr_word_o,
  input logic [2:0]  form_code_o,
  input logic        last_word_o
);

  // A stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(word_index_o) &&
      $stable(instr_word_o) && $stable(form_code_o) && $stable(last_word_o))
    else $error("stalled output beat changed");

  // Every sequence opens with a nop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (word_index_o == 3'd0) |-> instr_word_o == plt_enc_pkg::OP_NOP)
    else $error("first word is not a nop");

  // The last flag falls on the final word of the form
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_word_o ==
      (word_index_o == plt_enc_pkg::last_index(plt_enc_pkg::form_e'(form_code_o))))
    else $error("last flag does not match form length");

  // After a non-final word the next word of the same entry follows at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_word_o |=>
      out_valid_o && (form_code_o == $past(form_code_o)) &&
      (word_index_o == $past(word_index_o) + 3'd1))
    else $error("word sequence broken");

endmodule

bind plt_trampoline_encoder plt_enc_checker u_plt_enc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .word_index_o (word_index_o),
  .instr_word_o (instr_word_o),
  .form_code_o  (form_code_o),
  .last_word_o  (last_word_o)
);
